@@ rtl/clcd_pkg.sv @@
package clcd_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned ValueW  = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned CursorW = 7;

  typedef enum logic [KindW-1:0] {
    KindCmd  = 2'd0,
    KindData = 2'd1,
    KindRead = 2'd2,
    KindRsvd = 2'd3
  } kind_e;

  localparam logic [ValueW-1:0] CmdTwoLine  = 8'h28;
  localparam logic [ValueW-1:0] CmdAutoInc  = 8'h06;
  localparam logic [ValueW-1:0] CmdDispOn   = 8'h0C;
  localparam logic [ValueW-1:0] CmdDispOff  = 8'h08;
  localparam logic [ValueW-1:0] CmdClear    = 8'h01;
  localparam logic [ValueW-1:0] CmdCurRight = 8'h14;
  localparam logic [3:0]        CmdLine1Hi  = 4'h8;
  localparam logic [3:0]        CmdLine2Hi  = 4'hC;

  typedef struct packed {
    logic display_on;
    logic two_line;
    logic auto_inc;
  } flags_t;

  typedef struct packed {
    logic wr_en;
    logic clear;
  } ctl_t;

  function automatic logic [CodeW-1:0] glyph_code(logic [ValueW-1:0] b);
    logic [CodeW-1:0] code;
    case (b)
      8'h00:   code = 16'h0131;
      8'h01:   code = 16'h00FC;
      8'h02:   code = 16'h00F6;
      8'h03:   code = 16'h011F;
      8'h04:   code = 16'h00E7;
      8'h05:   code = 16'h00D6;
      8'hDF:   code = 16'h00B0;
      8'h7E:   code = 16'h2192;
      default: code = {{(CodeW-ValueW){1'b0}}, b};
    endcase
    return code;
  endfunction

endpackage

@@ rtl/clcd_if.sv @@
interface clcd_in_if;
  logic                          valid;
  logic                          ready;
  logic [clcd_pkg::KindW-1:0]    kind;
  logic [clcd_pkg::ValueW-1:0]   value;
  logic [clcd_pkg::IndexW-1:0]   cell_index;

  modport source (output valid, kind, value, cell_index, input ready);
  modport sink   (input valid, kind, value, cell_index, output ready);
endinterface

interface clcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [clcd_pkg::CodeW-1:0]    cell_code;
  logic [clcd_pkg::CursorW-1:0]  cursor;
  logic                          display_on;
  logic                          two_line_mode;
  logic                          auto_increment;

  modport source (output valid, cell_code, cursor, display_on, two_line_mode,
                  auto_increment, input ready);
  modport sink   (input valid, cell_code, cursor, display_on, two_line_mode,
                  auto_increment, output ready);
endinterface

@@ rtl/char_lcd_controller_top.sv @@
// Character display controller: takes one item per clock (command, data write or cell read)
// and presents its result from an output register in the cycle after acceptance; a new item
// is taken whenever that register is empty or being emptied, so throughput is one item per
// cycle under no back-pressure. The display store is a Rows*Cols x 16 RAM with a registered
// read port; a per-entry valid bit makes reset and the clear command take effect at once,
// with no clearing pass. The cursor and mode flags on the output are the state after the item.
module char_lcd_controller_top #(
  parameter int unsigned Cols = 20,
  parameter int unsigned Rows = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clcd_in_if.sink    in_i,
  clcd_out_if.source out_o
);

  localparam int unsigned NCells = Cols * Rows;
  localparam int unsigned CurW   = $clog2(NCells);
  localparam logic [CurW:0] SpanOne = (CurW+1)'(2 * Cols);
  localparam logic [CurW:0] SpanTwo = (CurW+1)'(NCells);

  logic                         acc;
  logic                         ovld_q;
  logic [CurW-1:0]              cur_q, cur_d;
  clcd_pkg::flags_t             flags_q, flags_d;
  clcd_pkg::ctl_t               ctl;
  logic [clcd_pkg::CodeW-1:0]   wdata;
  logic [clcd_pkg::CodeW-1:0]   rdata;
  logic [NCells-1:0]            vld_q;
  logic                         rd_hit_q;
  logic                         is_read;
  logic                         in_range;
  logic [CurW-1:0]              raddr;

  assign in_i.ready = !ovld_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign is_read    = (clcd_pkg::kind_e'(in_i.kind) == clcd_pkg::KindRead);
  assign in_range   = (32'(in_i.cell_index) < NCells);
  assign raddr      = CurW'(in_i.cell_index);

  clcd_dec #(
    .Cols (Cols),
    .Rows (Rows)
  ) u_dec (
    .kind_i   (in_i.kind),
    .value_i  (in_i.value),
    .cursor_i (cur_q),
    .flags_i  (flags_q),
    .cursor_o (cur_d),
    .flags_o  (flags_d),
    .ctl_o    (ctl),
    .wdata_o  (wdata)
  );

  clcd_ram #(
    .Width (clcd_pkg::CodeW),
    .Depth (NCells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc && ctl.wr_en),
    .waddr_i (cur_q),
    .wdata_i (wdata),
    .re_i    (acc && is_read && in_range),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q   <= 1'b0;
      cur_q    <= '0;
      flags_q  <= '0;
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (acc) begin
        ovld_q   <= 1'b1;
        cur_q    <= cur_d;
        flags_q  <= flags_d;
        // out-of-range index is masked before the valid bit matters
        rd_hit_q <= is_read && in_range && vld_q[raddr];
        if (ctl.clear) begin
          vld_q <= '0;
        end else if (ctl.wr_en) begin
          vld_q[cur_q] <= 1'b1;
        end
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // state registers only change on accept, so they already show this item's result
  assign out_o.valid          = ovld_q;
  assign out_o.cell_code      = rd_hit_q ? rdata : '0;
  assign out_o.cursor         = clcd_pkg::CursorW'(cur_q);
  assign out_o.display_on     = flags_q.display_on;
  assign out_o.two_line_mode  = flags_q.two_line;
  assign out_o.auto_increment = flags_q.auto_inc;

  a_cursor_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_q} < (flags_q.two_line ? SpanTwo : SpanOne)))
    else $error("cursor outside span");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && ctl.clear) |=> (vld_q == '0))
    else $error("clear left valid cells");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_o.valid)
    else $error("accepted item has no result");

  a_two_line_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(flags_q.two_line))
    else $error("two-line mode dropped");

endmodule

@@ rtl/clcd_ram.sv @@
module clcd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 80,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/clcd_dec.sv @@
module clcd_dec #(
  parameter int unsigned Cols = 20,
  parameter int unsigned Rows = 4,
  localparam int unsigned NCells = Cols * Rows,
  localparam int unsigned CurW = $clog2(NCells)
) (
  input  logic [clcd_pkg::KindW-1:0]  kind_i,
  input  logic [clcd_pkg::ValueW-1:0] value_i,
  input  logic [CurW-1:0]             cursor_i,
  input  clcd_pkg::flags_t            flags_i,
  output logic [CurW-1:0]             cursor_o,
  output clcd_pkg::flags_t            flags_o,
  output clcd_pkg::ctl_t              ctl_o,
  output logic [clcd_pkg::CodeW-1:0]  wdata_o
);

  localparam logic [CurW:0]   SpanOne = (CurW+1)'(2 * Cols);
  localparam logic [CurW:0]   SpanTwo = (CurW+1)'(NCells);
  localparam logic [CurW-1:0] Line2At = CurW'(2 * Cols);

  logic [CurW:0]   inc;
  logic [CurW:0]   span;
  logic [CurW-1:0] wrapped;
  logic [CurW-1:0] line2_base;

  assign span       = flags_i.two_line ? SpanTwo : SpanOne;
  assign inc        = {1'b0, cursor_i} + (CurW+1)'(1);
  assign wrapped    = (inc >= span) ? '0 : inc[CurW-1:0];
  // line 2 starts at 2*cols only when the span is wider than two lines
  assign line2_base = (flags_i.two_line && (Rows > 2)) ? Line2At : '0;
  assign wdata_o    = clcd_pkg::glyph_code(value_i);

  always_comb begin
    cursor_o    = cursor_i;
    flags_o     = flags_i;
    ctl_o.wr_en = 1'b0;
    ctl_o.clear = 1'b0;
    case (clcd_pkg::kind_e'(kind_i))
      clcd_pkg::KindCmd: begin
        case (value_i)
          clcd_pkg::CmdTwoLine:  flags_o.two_line   = 1'b1;
          clcd_pkg::CmdAutoInc:  flags_o.auto_inc   = 1'b1;
          clcd_pkg::CmdDispOn:   flags_o.display_on = 1'b1;
          clcd_pkg::CmdDispOff:  flags_o.display_on = 1'b0;
          clcd_pkg::CmdClear: begin
            ctl_o.clear = 1'b1;
            cursor_o    = '0;
          end
          clcd_pkg::CmdCurRight: cursor_o = wrapped;
          default: begin
            if (value_i[7:4] == clcd_pkg::CmdLine1Hi) begin
              cursor_o = CurW'(value_i[3:0]);
            end else if (value_i[7:4] == clcd_pkg::CmdLine2Hi) begin
              cursor_o = line2_base + CurW'(value_i[3:0]);
            end
          end
        endcase
      end
      clcd_pkg::KindData: begin
        ctl_o.wr_en = 1'b1;
        if (flags_i.auto_inc) begin
          cursor_o = wrapped;
        end
      end
      default: ;
    endcase
  end

endmodule
